>>> src/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared constants and types for the software timer pool.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int NUM_TIMERS_DEF     = 8;
    localparam int ADDRESSABLE_SLOTS  = 8;

    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 3;
    localparam int DUR_W      = 32;
    localparam int TIME_W     = 32;
    localparam int GRANT_W    = 4;
    localparam int TICK_W     = 4;

    localparam int IN_TDATA_W  = 40;   // 3 + 3 + 32, padded to bytes
    localparam int OUT_TDATA_W = 8;    // 4 + 1, padded to bytes

    localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESTART  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RELEASE  = 3'd4;

    localparam logic [GRANT_W-1:0]  SLOT_NONE        = 4'd8;
    localparam logic [7:0]          TOP_BYTE_LIMIT   = 8'hF0;
    localparam logic [DUR_W-1:0]    CLAMPED_DURATION = 32'hF0FF_FFFF;
    localparam logic [TICK_W-1:0]   TICK_INC_RESET   = 4'd2;

    // flag update operations
    localparam logic [2:0] FLG_NONE    = 3'd0;
    localparam logic [2:0] FLG_ALLOC   = 3'd1;
    localparam logic [2:0] FLG_RESTART = 3'd2;
    localparam logic [2:0] FLG_RELEASE = 3'd3;
    localparam logic [2:0] FLG_EXPIRE  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic       busy_set;   // allocated duration is nonzero
    } flag_upd_t;

endpackage

>>> src/stp_slot_mem.sv
// ----------------------------------------------------------------------------
// stp_slot_mem
// Start time and duration store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stp_slot_mem #(
    parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF,
    parameter int AW         = 3
) (
    input  logic                     clk,
    input  logic                     wr_start_en,
    input  logic                     wr_dur_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [stp_pkg::TIME_W-1:0] wr_start,
    input  logic [stp_pkg::DUR_W-1:0]  wr_dur,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [stp_pkg::TIME_W-1:0] rd_start,
    output logic [stp_pkg::DUR_W-1:0]  rd_dur
);
    import stp_pkg::*;

    logic [TIME_W-1:0] start_mem [NUM_TIMERS];
    logic [DUR_W-1:0]  dur_mem   [NUM_TIMERS];

    always_ff @(posedge clk)
    begin
        if (wr_start_en)
        begin
            start_mem[wr_addr] <= wr_start;
        end
        if (wr_dur_en)
        begin
            dur_mem[wr_addr] <= wr_dur;
        end
        if (rd_en)
        begin
            rd_start <= start_mem[rd_addr];
            rd_dur   <= dur_mem[rd_addr];
        end
    end

endmodule

>>> src/stp_flags.sv
// ----------------------------------------------------------------------------
// stp_flags
// Per-slot busy (duration nonzero) and running bits, plus lowest-free search.
// ----------------------------------------------------------------------------
module stp_flags #(
    parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF,
    parameter int AW         = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stp_pkg::flag_upd_t         upd,
    input  logic [AW-1:0]              upd_addr,
    input  logic [AW-1:0]              q_addr,
    output logic                       q_busy,
    output logic                       q_running,
    output logic                       free_found,
    output logic [stp_pkg::SLOT_W-1:0] free_idx
);
    import stp_pkg::*;

    localparam int LIM = (NUM_TIMERS < ADDRESSABLE_SLOTS) ? NUM_TIMERS : ADDRESSABLE_SLOTS;

    logic [NUM_TIMERS-1:0] busy_reg, busy_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;

    always_comb
    begin
        busy_next    = busy_reg;
        running_next = running_reg;
        unique case (upd.op)
            FLG_ALLOC:
            begin
                busy_next[upd_addr]    = upd.busy_set;
                running_next[upd_addr] = 1'b1;
            end
            FLG_RESTART:
            begin
                running_next[upd_addr] = 1'b1;
            end
            FLG_RELEASE:
            begin
                busy_next[upd_addr]    = 1'b0;
                running_next[upd_addr] = 1'b0;
            end
            FLG_EXPIRE:
            begin
                running_next[upd_addr] = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= '0;
            running_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            running_reg <= running_next;
        end
    end

    assign q_busy    = busy_reg[q_addr];
    assign q_running = running_reg[q_addr];

    // lowest index wins
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = LIM - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

endmodule

>>> src/software_timer_pool_core.sv
// ----------------------------------------------------------------------------
// software_timer_pool_core
// Microsecond time base advanced by tick words, with a pool of one-shot timer slots.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word. Tick, allocate, restart,
// release and unknown actions can follow back to back while the output is not
// stalled; a check of an existing slot passes through a check state, because
// the start time and duration come out of the slot memory registered, before
// the elapsed-time compare. Checks of nonexistent slots are answered directly.
// The output register lets a new word be accepted in the cycle its predecessor's
// result is taken. The tick increment may be changed only while idle.
module software_timer_pool_core #(
    parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stp_pkg::TICK_W-1:0]     cfg_data,       // tick_increment
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] action, [5:3] slot_index, [37:6] duration_us, [39:38] zero
    input  logic [stp_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] granted_slot, [4] expired, [7:5] zero
    output logic [stp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import stp_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    logic                state_reg, state_next;
    logic [TICK_W-1:0]   tick_inc_reg;
    logic [TIME_W-1:0]   time_now_reg, time_now_next;
    logic [AW-1:0]       chk_addr_reg, chk_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [GRANT_W-1:0]  out_slot_reg, out_slot_next;
    logic                out_exp_reg, out_exp_next;

    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;
    logic [DUR_W-1:0]    duration_us;
    logic [DUR_W-1:0]    dur_clamped;
    logic                acc;
    logic                slot_ok;
    logic [AW-1:0]       slot_addr;

    logic                wr_start_en, wr_dur_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [TIME_W-1:0]   rd_start;
    logic [DUR_W-1:0]    rd_dur;

    flag_upd_t           upd;
    logic [AW-1:0]       upd_addr;
    logic                q_busy, q_running;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;

    logic [TIME_W-1:0]   elapsed;
    logic [DUR_W-1:0]    dur_eff;
    logic                late;

    assign action      = s_tdata[2:0];
    assign slot_index  = s_tdata[5:3];
    assign duration_us = s_tdata[37:6];
    assign dur_clamped = (duration_us[31:24] > TOP_BYTE_LIMIT) ? CLAMPED_DURATION
                                                              : duration_us;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign acc       = s_tvalid && s_tready;
    assign slot_ok   = (32'(slot_index) < NUM_TIMERS);
    assign slot_addr = AW'(slot_index);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_exp_reg, out_slot_reg};

    // check stage: data of chk_addr_reg is in rd_start / rd_dur
    assign elapsed = time_now_reg - rd_start;
    assign dur_eff = q_busy ? rd_dur : '0;
    assign late    = elapsed > dur_eff;

    always_comb
    begin
        state_next     = state_reg;
        time_now_next  = time_now_reg;
        chk_addr_next  = chk_addr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_slot_next  = out_slot_reg;
        out_exp_next   = out_exp_reg;
        wr_start_en    = 1'b0;
        wr_dur_en      = 1'b0;
        wr_addr        = slot_addr;
        rd_en          = 1'b0;
        upd.op         = FLG_NONE;
        upd.busy_set   = 1'b0;
        upd_addr       = slot_addr;

        if (state_reg == ST_CHECK)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = SLOT_NONE;
            out_exp_next   = !q_running || late;
            upd_addr       = chk_addr_reg;
            if (q_running && late)
            begin
                upd.op = FLG_EXPIRE;
            end
            state_next = ST_IDLE;
        end
        else if (acc)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = SLOT_NONE;
            out_exp_next   = 1'b0;
            unique case (action)
                ACT_TICK:
                begin
                    time_now_next = time_now_reg + TIME_W'(tick_inc_reg);
                end
                ACT_ALLOC:
                begin
                    if (free_found)
                    begin
                        wr_start_en   = 1'b1;
                        wr_dur_en     = 1'b1;
                        wr_addr       = AW'(free_idx);
                        upd.op        = FLG_ALLOC;
                        upd.busy_set  = (dur_clamped != '0);
                        upd_addr      = AW'(free_idx);
                        out_slot_next = GRANT_W'(free_idx);
                    end
                end
                ACT_CHECK:
                begin
                    if (slot_ok)
                    begin
                        rd_en          = 1'b1;
                        chk_addr_next  = slot_addr;
                        out_valid_next = 1'b0;
                        state_next     = ST_CHECK;
                    end
                    else
                    begin
                        out_exp_next = 1'b1;
                    end
                end
                ACT_RESTART:
                begin
                    if (slot_ok)
                    begin
                        wr_start_en = 1'b1;
                        upd.op      = FLG_RESTART;
                    end
                end
                ACT_RELEASE:
                begin
                    if (slot_ok)
                    begin
                        upd.op = FLG_RELEASE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_inc_reg  <= TICK_INC_RESET;
            time_now_reg  <= '0;
            chk_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_now_reg  <= time_now_next;
            chk_addr_reg  <= chk_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tick_inc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg <= out_slot_next;
        out_exp_reg  <= out_exp_next;
    end

    stp_slot_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .AW         (AW)
    ) u_mem (
        .clk         (clk),
        .wr_start_en (wr_start_en),
        .wr_dur_en   (wr_dur_en),
        .wr_addr     (wr_addr),
        .wr_start    (time_now_reg),
        .wr_dur      (dur_clamped),
        .rd_en       (rd_en),
        .rd_addr     (slot_addr),
        .rd_start    (rd_start),
        .rd_dur      (rd_dur)
    );

    stp_flags #(
        .NUM_TIMERS (NUM_TIMERS),
        .AW         (AW)
    ) u_flags (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .upd_addr   (upd_addr),
        .q_addr     (chk_addr_reg),
        .q_busy     (q_busy),
        .q_running  (q_running),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    // check state always returns to idle
    a_check_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |=> (state_reg == ST_IDLE))
        else $error("check stage did not return to idle");

    // output register must be empty while a check result is being formed
    a_check_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> !out_valid_reg)
        else $error("output occupied during check stage");

    // every accepted word other than a memory check produces a result next cycle
    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !rd_en) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("missing direct result");

    // memory read only issued for an accepted in-range check
    a_read_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_CHECK))
        else $error("memory read without check stage");

    // a successful grant names a slot that now runs
    a_grant_running: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.op == FLG_ALLOC) |=> (out_slot_reg != SLOT_NONE))
        else $error("allocate grant lost");

endmodule
